@@ sv/cra_pkg.sv @@
// Shared types, constants and tables of the complex ALU with polar output.
package cra_pkg;

   localparam int DATA_W        = 16;
   localparam int FRAC_BITS     = 12;
   localparam int CORDIC_STAGES = 16;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;

   // quotient bits kept before saturation, wide values, divider remainder
   localparam int Q_BITS  = DATA_W + 1;
   localparam int VAL_W   = 2 * DATA_W + 2;
   localparam int DEN_W   = 2 * DATA_W;
   localparam int DIV_W   = 2 * DATA_W + ((FRAC_BITS > Q_BITS) ? FRAC_BITS : Q_BITS) + 2;

   // CORDIC datapath
   localparam int GUARD_BITS = 8;
   localparam int ANG_EXTRA  = 5;
   localparam int CX_W       = DATA_W + GUARD_BITS + 3;
   localparam int Z_W        = DATA_W + ANG_EXTRA + 2;
   localparam int GAIN_W     = 16;
   localparam int PROD_W     = CX_W + GAIN_W;
   localparam int MAG_SHIFT  = 24;
   localparam logic [GAIN_W-1:0] INV_GAIN = 16'd39797;
   localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(16384 * 32);

   localparam logic signed [VAL_W-1:0] RND_HALF = VAL_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [VAL_W-1:0] SAT_MAX  = VAL_W'(32767);
   localparam logic signed [VAL_W-1:0] SAT_MIN  = -VAL_W'(32768);

   localparam logic signed [DATA_W-1:0] ANG_ZERO    = 16'sd0;
   localparam logic signed [DATA_W-1:0] ANG_PI_HALF = 16'sd16384;
   localparam logic signed [DATA_W-1:0] ANG_PI      = -16'sd32768;

   // op codes
   localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL   = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV   = 3'd3;
   localparam logic [OP_W-1:0] OP_ADDR  = 3'd4;
   localparam logic [OP_W-1:0] OP_SUBR  = 3'd5;
   localparam logic [OP_W-1:0] OP_SCALE = 3'd6;
   localparam logic [OP_W-1:0] OP_DIVR  = 3'd7;

   // work kinds after decode
   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_MUL  = 2'd1;
   localparam logic [1:0] KIND_DIVC = 2'd2;
   localparam logic [1:0] KIND_DIVR = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DZ  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

   typedef struct packed {
      logic [1:0]               kind;
      logic                     sub;
      logic                     dz;
      logic signed [DATA_W-1:0] a_re;
      logic signed [DATA_W-1:0] a_im;
      logic signed [DATA_W-1:0] b_re;
      logic signed [DATA_W-1:0] b_im;
   } cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic [DATA_W-1:0]        mag;
      logic signed [DATA_W-1:0] angle;
      logic [STATUS_W-1:0]      status;
   } res_type;

   // atan(2^-i) in units of pi/2^20
   function automatic logic signed [Z_W-1:0] atan_entry(input int i);
      logic signed [Z_W-1:0] v;
      unique case (i)
         0: v = Z_W'(262144);
         1: v = Z_W'(154753);
         2: v = Z_W'(81767);
         3: v = Z_W'(41506);
         4: v = Z_W'(20834);
         5: v = Z_W'(10427);
         6: v = Z_W'(5215);
         7: v = Z_W'(2608);
         8: v = Z_W'(1304);
         9: v = Z_W'(652);
         10: v = Z_W'(326);
         11: v = Z_W'(163);
         12: v = Z_W'(81);
         13: v = Z_W'(41);
         14: v = Z_W'(20);
         15: v = Z_W'(10);
         16: v = Z_W'(5);
         17: v = Z_W'(3);
         18: v = Z_W'(1);
         19: v = Z_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [2*DATA_W-1:0] smul(input logic signed [DATA_W-1:0] x,
                                                       input logic signed [DATA_W-1:0] y);
      logic signed [2*DATA_W-1:0] xe;
      logic signed [2*DATA_W-1:0] ye;
      xe = (2*DATA_W)'(x);
      ye = (2*DATA_W)'(y);
      return xe * ye;
   endfunction

endpackage

@@ sv/cra_front.sv @@
// Front end: accept requests, decode the op and flag division by zero.
module cra_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [cra_pkg::OP_W-1:0]  op,
   input  logic signed [cra_pkg::DATA_W-1:0] a_re,
   input  logic signed [cra_pkg::DATA_W-1:0] a_im,
   input  logic signed [cra_pkg::DATA_W-1:0] b_re,
   input  logic signed [cra_pkg::DATA_W-1:0] b_im,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output cra_pkg::cmd_type  cmd
);
   import cra_pkg::*;

   logic    valid_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    b_re_zero;

   assign req_ready = !valid_ff || cmd_ready;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;
   assign b_re_zero = (b_re == '0);

   always_comb begin
      cmd_in      = '0;
      cmd_in.a_re = a_re;
      cmd_in.a_im = a_im;
      cmd_in.b_re = b_re;
      cmd_in.b_im = b_im;
      unique case (op)
         OP_ADD:   cmd_in.kind = KIND_ADD;
         OP_SUB: begin
            cmd_in.kind = KIND_ADD;
            cmd_in.sub  = 1'b1;
         end
         OP_MUL:   cmd_in.kind = KIND_MUL;
         OP_DIV: begin
            cmd_in.kind = KIND_DIVC;
            cmd_in.dz   = b_re_zero && (b_im == '0);
         end
         OP_ADDR: begin
            cmd_in.kind = KIND_ADD;
            cmd_in.b_im = '0;
         end
         OP_SUBR: begin
            cmd_in.kind = KIND_ADD;
            cmd_in.sub  = 1'b1;
            cmd_in.b_im = '0;
         end
         OP_SCALE: begin
            cmd_in.kind = KIND_MUL;
            cmd_in.b_im = '0;
         end
         default: begin
            cmd_in.kind = KIND_DIVR;
            cmd_in.b_im = '0;
            cmd_in.dz   = b_re_zero;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

@@ sv/cra_fifo.sv @@
// Two-entry command queue between the front end and the arithmetic pipeline.
module cra_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cra_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output cra_pkg::cmd_type out_cmd
);
   import cra_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;
   logic       push;
   logic       pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_cmd;
      end
   end

endmodule

@@ sv/cra_back.sv @@
// Arithmetic pipeline: products, combine, restoring divider, CORDIC, gain correction, output register.
module cra_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  cra_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cra_pkg::res_type rsp
);
   import cra_pkg::*;

   typedef struct packed {
      logic [1:0]                 kind;
      logic                       sub;
      logic                       dz;
      logic signed [DATA_W-1:0]   a_re;
      logic signed [DATA_W-1:0]   a_im;
      logic signed [DATA_W-1:0]   b_re;
      logic signed [DATA_W-1:0]   b_im;
      logic signed [2*DATA_W-1:0] p_rr;
      logic signed [2*DATA_W-1:0] p_ii;
      logic signed [2*DATA_W-1:0] p_ri;
      logic signed [2*DATA_W-1:0] p_ir;
      logic signed [2*DATA_W-1:0] p_bb;
      logic signed [2*DATA_W-1:0] p_cc;
   } prod_type;

   typedef struct packed {
      logic                    dz;
      logic                    is_div;
      logic signed [VAL_W-1:0] val_re;
      logic signed [VAL_W-1:0] val_im;
      logic signed [VAL_W-1:0] n_re;
      logic signed [VAL_W-1:0] n_im;
      logic [DEN_W-1:0]        den;
   } comb_type;

   typedef struct packed {
      logic                    dz;
      logic                    is_div;
      logic signed [VAL_W-1:0] val_re;
      logic signed [VAL_W-1:0] val_im;
      logic                    neg_re;
      logic                    neg_im;
      logic                    ovf_re;
      logic                    ovf_im;
      logic [DIV_W-1:0]        r_re;
      logic [DIV_W-1:0]        r_im;
      logic [DEN_W-1:0]        den;
      logic [Q_BITS-1:0]       q_re;
      logic [Q_BITS-1:0]       q_im;
   } div_type;

   typedef struct packed {
      logic                     dz;
      logic                     sat;
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic signed [CX_W-1:0]   x;
      logic signed [CX_W-1:0]   y;
      logic signed [Z_W-1:0]    z;
   } cor_type;

   typedef struct packed {
      logic                     dz;
      logic                     sat;
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic signed [Z_W-1:0]    z;
      logic [PROD_W-1:0]        prod;
   } mag_type;

   function automatic logic signed [VAL_W-1:0] div_value(input logic is_div,
         input logic signed [VAL_W-1:0] val, input logic neg, input logic ovf,
         input logic [Q_BITS-1:0] q);
      logic signed [VAL_W-1:0] m;
      if (!is_div) return val;
      m = ovf ? (VAL_W'(1) << Q_BITS) : VAL_W'(q);
      return neg ? -m : m;
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp16(input logic signed [VAL_W-1:0] v);
      if (v > SAT_MAX) return DATA_W'(SAT_MAX);
      if (v < SAT_MIN) return DATA_W'(SAT_MIN);
      return DATA_W'(v);
   endfunction

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign cmd_ready = adv;

   // products
   logic     p_v_ff;
   prod_type p_ff;

   always_ff @(posedge clock) begin
      if (reset) p_v_ff <= 1'b0;
      else if (adv) p_v_ff <= cmd_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff.kind <= cmd.kind;
         p_ff.sub  <= cmd.sub;
         p_ff.dz   <= cmd.dz;
         p_ff.a_re <= cmd.a_re;
         p_ff.a_im <= cmd.a_im;
         p_ff.b_re <= cmd.b_re;
         p_ff.b_im <= cmd.b_im;
         p_ff.p_rr <= smul(cmd.a_re, cmd.b_re);
         p_ff.p_ii <= smul(cmd.a_im, cmd.b_im);
         p_ff.p_ri <= smul(cmd.a_re, cmd.b_im);
         p_ff.p_ir <= smul(cmd.a_im, cmd.b_re);
         p_ff.p_bb <= smul(cmd.b_re, cmd.b_re);
         p_ff.p_cc <= smul(cmd.b_im, cmd.b_im);
      end
   end

   // combine per kind
   logic     c_v_ff;
   comb_type c_ff;
   comb_type c_in;
   logic signed [VAL_W-1:0] ar_w, ai_w, br_w, bi_w;

   always_comb begin
      ar_w = VAL_W'(p_ff.a_re);
      ai_w = VAL_W'(p_ff.a_im);
      br_w = VAL_W'(p_ff.b_re);
      bi_w = VAL_W'(p_ff.b_im);
      c_in = '0;
      c_in.dz = p_ff.dz;
      unique case (p_ff.kind)
         KIND_ADD: begin
            c_in.val_re = p_ff.sub ? ar_w - br_w : ar_w + br_w;
            c_in.val_im = p_ff.sub ? ai_w - bi_w : ai_w + bi_w;
         end
         KIND_MUL: begin
            c_in.val_re = (VAL_W'(p_ff.p_rr) - VAL_W'(p_ff.p_ii) + RND_HALF) >>> FRAC_BITS;
            c_in.val_im = (VAL_W'(p_ff.p_ri) + VAL_W'(p_ff.p_ir) + RND_HALF) >>> FRAC_BITS;
         end
         KIND_DIVC: begin
            c_in.is_div = 1'b1;
            c_in.n_re   = VAL_W'(p_ff.p_rr) + VAL_W'(p_ff.p_ii);
            c_in.n_im   = VAL_W'(p_ff.p_ir) - VAL_W'(p_ff.p_ri);
            c_in.den    = DEN_W'($unsigned(p_ff.p_bb)) + DEN_W'($unsigned(p_ff.p_cc));
         end
         default: begin
            c_in.is_div = 1'b1;
            c_in.n_re   = p_ff.b_re[DATA_W-1] ? -ar_w : ar_w;
            c_in.n_im   = p_ff.b_re[DATA_W-1] ? -ai_w : ai_w;
            c_in.den    = DEN_W'(p_ff.b_re[DATA_W-1] ? -br_w : br_w);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else if (adv) c_v_ff <= p_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) c_ff <= c_in;
   end

   // divider: setup stage, then one quotient bit per stage
   logic    dv_v_ff [Q_BITS+1];
   div_type dv_ff   [Q_BITS+1];
   div_type dv_in0;
   logic [VAL_W-1:0] mag_re, mag_im;
   logic [DIV_W-1:0] top_lim;

   always_comb begin
      dv_in0        = '0;
      dv_in0.dz     = c_ff.dz;
      dv_in0.is_div = c_ff.is_div;
      dv_in0.val_re = c_ff.val_re;
      dv_in0.val_im = c_ff.val_im;
      dv_in0.den    = c_ff.den;
      dv_in0.neg_re = c_ff.n_re[VAL_W-1];
      dv_in0.neg_im = c_ff.n_im[VAL_W-1];
      mag_re  = dv_in0.neg_re ? -c_ff.n_re : c_ff.n_re;
      mag_im  = dv_in0.neg_im ? -c_ff.n_im : c_ff.n_im;
      top_lim = DIV_W'(c_ff.den) << Q_BITS;
      dv_in0.r_re   = (DIV_W'(mag_re) << FRAC_BITS) + DIV_W'(c_ff.den >> 1);
      dv_in0.r_im   = (DIV_W'(mag_im) << FRAC_BITS) + DIV_W'(c_ff.den >> 1);
      dv_in0.ovf_re = (dv_in0.r_re >= top_lim);
      dv_in0.ovf_im = (dv_in0.r_im >= top_lim);
   end

   always_ff @(posedge clock) begin
      if (reset) dv_v_ff[0] <= 1'b0;
      else if (adv) dv_v_ff[0] <= c_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) dv_ff[0] <= dv_in0;
   end

   for (genvar k = 1; k <= Q_BITS; k++) begin : g_div
      localparam int SH = Q_BITS - k;
      div_type          nxt;
      logic [DIV_W-1:0] trial;

      always_comb begin
         nxt   = dv_ff[k-1];
         trial = DIV_W'(dv_ff[k-1].den) << SH;
         if (dv_ff[k-1].r_re >= trial) begin
            nxt.r_re     = dv_ff[k-1].r_re - trial;
            nxt.q_re[SH] = 1'b1;
         end
         if (dv_ff[k-1].r_im >= trial) begin
            nxt.r_im     = dv_ff[k-1].r_im - trial;
            nxt.q_im[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[k] <= 1'b0;
         else if (adv) dv_v_ff[k] <= dv_v_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv) dv_ff[k] <= nxt;
      end
   end

   // saturate and pre-rotate into the right half plane
   logic    cr_v_ff [CORDIC_STAGES+1];
   cor_type cr_ff   [CORDIC_STAGES+1];
   cor_type cr_in0;
   logic signed [VAL_W-1:0] fv_re, fv_im;
   logic signed [CX_W-1:0]  x0, y0;

   always_comb begin
      fv_re = div_value(dv_ff[Q_BITS].is_div, dv_ff[Q_BITS].val_re, dv_ff[Q_BITS].neg_re,
                        dv_ff[Q_BITS].ovf_re, dv_ff[Q_BITS].q_re);
      fv_im = div_value(dv_ff[Q_BITS].is_div, dv_ff[Q_BITS].val_im, dv_ff[Q_BITS].neg_im,
                        dv_ff[Q_BITS].ovf_im, dv_ff[Q_BITS].q_im);
      cr_in0    = '0;
      cr_in0.dz = dv_ff[Q_BITS].dz;
      if (!dv_ff[Q_BITS].dz) begin
         cr_in0.re  = clamp16(fv_re);
         cr_in0.im  = clamp16(fv_im);
         cr_in0.sat = (fv_re > SAT_MAX) || (fv_re < SAT_MIN) ||
                      (fv_im > SAT_MAX) || (fv_im < SAT_MIN);
      end
      x0 = CX_W'(cr_in0.re) <<< GUARD_BITS;
      y0 = CX_W'(cr_in0.im) <<< GUARD_BITS;
      cr_in0.x = x0;
      cr_in0.y = y0;
      if (x0 < 0) begin
         if (y0 >= 0) begin
            cr_in0.x = y0;
            cr_in0.y = -x0;
            cr_in0.z = QUARTER_TURN;
         end else begin
            cr_in0.x = -y0;
            cr_in0.y = x0;
            cr_in0.z = -QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cr_v_ff[0] <= 1'b0;
      else if (adv) cr_v_ff[0] <= dv_v_ff[Q_BITS];
   end

   always_ff @(posedge clock) begin
      if (adv) cr_ff[0] <= cr_in0;
   end

   for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_cordic
      localparam int SH = k - 1;
      cor_type nxt;

      always_comb begin
         nxt = cr_ff[k-1];
         if (cr_ff[k-1].y >= 0) begin
            nxt.x = cr_ff[k-1].x + (cr_ff[k-1].y >>> SH);
            nxt.y = cr_ff[k-1].y - (cr_ff[k-1].x >>> SH);
            nxt.z = cr_ff[k-1].z + atan_entry(SH);
         end else begin
            nxt.x = cr_ff[k-1].x - (cr_ff[k-1].y >>> SH);
            nxt.y = cr_ff[k-1].y + (cr_ff[k-1].x >>> SH);
            nxt.z = cr_ff[k-1].z - atan_entry(SH);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) cr_v_ff[k] <= 1'b0;
         else if (adv) cr_v_ff[k] <= cr_v_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv) cr_ff[k] <= nxt;
      end
   end

   // gain correction product
   logic    mg_v_ff;
   mag_type mg_ff;
   logic [CX_W-1:0] xpos;

   assign xpos = cr_ff[CORDIC_STAGES].x[CX_W-1] ? '0 : CX_W'(cr_ff[CORDIC_STAGES].x);

   always_ff @(posedge clock) begin
      if (reset) mg_v_ff <= 1'b0;
      else if (adv) mg_v_ff <= cr_v_ff[CORDIC_STAGES];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mg_ff.dz   <= cr_ff[CORDIC_STAGES].dz;
         mg_ff.sat  <= cr_ff[CORDIC_STAGES].sat;
         mg_ff.re   <= cr_ff[CORDIC_STAGES].re;
         mg_ff.im   <= cr_ff[CORDIC_STAGES].im;
         mg_ff.z    <= cr_ff[CORDIC_STAGES].z;
         mg_ff.prod <= PROD_W'(xpos) * PROD_W'(INV_GAIN);
      end
   end

   // round, clamp, fix special angles, hold for the consumer
   logic    out_v_ff;
   res_type out_ff;
   res_type out_in;
   logic [PROD_W-1:0]    mrnd;
   logic signed [Z_W-1:0] zr;

   always_comb begin
      mrnd = (mg_ff.prod + (PROD_W'(1) << (MAG_SHIFT - 1))) >> MAG_SHIFT;
      zr   = (mg_ff.z + (Z_W'(1) <<< (ANG_EXTRA - 1))) >>> ANG_EXTRA;
      out_in.re     = mg_ff.re;
      out_in.im     = mg_ff.im;
      out_in.mag    = (mrnd > PROD_W'(16'hFFFF)) ? 16'hFFFF : DATA_W'(mrnd);
      out_in.angle  = DATA_W'(zr);
      out_in.status = mg_ff.dz ? ST_DZ : (mg_ff.sat ? ST_SAT : ST_OK);
      if (mg_ff.re == '0 && mg_ff.im == '0) begin
         out_in.mag   = '0;
         out_in.angle = ANG_ZERO;
      end else if (mg_ff.re == '0) begin
         out_in.angle = (mg_ff.im > 0) ? ANG_PI_HALF : -ANG_PI_HALF;
      end else if (mg_ff.im == '0) begin
         out_in.angle = (mg_ff.re > 0) ? ANG_ZERO : ANG_PI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= mg_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp       = out_ff;

endmodule

@@ sv/complex_alu_rect_polar.sv @@
// Complex ALU with rectangular and polar result: top level.
// Path: front register, two-entry queue, then the back-end registers: products, combine,
// divider setup and stages, pre-rotate, CORDIC stages, gain product and output register.
// Throughput: one item per cycle unless rsp_tready stalls; divider and CORDIC are unrolled pipelines.
// Reset: synchronous, active high; clears all valid bits and the queue, no payload reset.
module complex_alu_rect_polar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // a_re[15:0], a_im[31:16], b_re[47:32], b_im[63:48]
   input  logic [7:0]  req_tuser,  // op[2:0], zero above
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // res_re[15:0], res_im[31:16], res_mag[47:32],
                                   // res_angle[63:48]
   output logic [7:0]  rsp_tuser   // status[1:0], zero above
);
   import cra_pkg::*;

   logic    f_valid, f_ready;
   cmd_type f_cmd;
   logic    q_valid, q_ready;
   cmd_type q_cmd;
   res_type res;

   cra_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .op        (req_tuser[OP_W-1:0]),
      .a_re      (req_tdata[15:0]),
      .a_im      (req_tdata[31:16]),
      .b_re      (req_tdata[47:32]),
      .b_im      (req_tdata[63:48]),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd       (f_cmd)
   );

   cra_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   cra_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (res)
   );

   assign rsp_tdata = {res.angle, res.mag, res.im, res.re};
   assign rsp_tuser = {6'd0, res.status};

endmodule
